FILE: rtl/arfvs_pkg.sv
// Shared types and constants for the audio ring FIFO with gain and saturation.
// No dependencies; imported by arfvs_gain and the top level.
`default_nettype none

package arfvs_pkg;

    localparam int RING_DEPTH = 2048;                 // power of two
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int SAMPLE_W   = 16;
    localparam int VOL_W      = 9;
    localparam int PROD_W     = SAMPLE_W + VOL_W + 1;  // signed product width
    localparam int SHIFT      = 8;
    localparam int SHR_W      = PROD_W - SHIFT;
    localparam int CFG_AW     = 3;

    localparam logic [VOL_W-1:0] VOLUME_RESET = VOL_W'(256);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    // register index = paddr[2]
    typedef enum logic {
        REG_VOLUME = 1'b0,
        REG_MUTE   = 1'b1
    } reg_idx_t;

    // per-word status carried from the pointer stage to the gain stage
    typedef struct packed {
        cmd_t cmd;
        logic dropped;
        logic was_empty;
    } word_stat_t;

endpackage

`default_nettype wire

FILE: rtl/arfvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module arfvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/arfvs_gain.sv
// Gain, floor shift and 16-bit saturation of one popped sample; pushes, empty pops and mute give zero.
// Depends on arfvs_pkg.
`default_nettype none

module arfvs_gain
    import arfvs_pkg::*;
(
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic        [VOL_W-1:0]    volume,
    input  wire logic                       mute,
    input  wire word_stat_t                 stat,
    output logic signed      [SAMPLE_W-1:0] out_sample
);

    logic signed [PROD_W-1:0] prod;
    logic signed [SHR_W-1:0]  shr;
    logic                     force_zero;

    always_comb begin
        prod = PROD_W'(sample) * $signed({1'b0, volume});
        // arithmetic shift gives floor rounding
        shr  = SHR_W'(prod >>> SHIFT);
        force_zero = (stat.cmd == CMD_PUSH) || stat.was_empty || mute;
        if (force_zero) begin
            out_sample = '0;
        end else if (shr > SHR_W'(SAMPLE_MAX)) begin
            out_sample = SAMPLE_MAX;
        end else if (shr < SHR_W'(SAMPLE_MIN)) begin
            out_sample = SAMPLE_MIN;
        end else begin
            out_sample = SAMPLE_W'(shr);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/audio_ring_fifo_volume_saturate_core.sv
// Top level of the mono audio ring FIFO with volume and saturation.
// Depends on arfvs_pkg, arfvs_ram and arfvs_gain.
`default_nettype none

// A push word (tuser = 0) stores its left-channel sample in a 2048-entry ring
// that keeps one slot free, so it holds up to 2047 samples; a push into a full
// ring is discarded and answered with dropped = 1. A pop word (tuser = 1) takes
// the oldest sample, scales it by volume_factor/256 with floor rounding and
// clamps it to signed 16 bits; an empty ring gives silence and was_empty = 1,
// mute gives zero but still consumes the sample. Every input word yields one
// output word, in order. The block takes one word per clock while the output
// is not stalled; a result passes through the registered ring read, then the
// multiply and clamp into the output register. Ring memory
// contents are not cleared at reset and need no clearing pass. Registers:
// 0x0 volume_factor (9 bits, reset 256), 0x4 mute (1 bit, reset 0); write
// them only while no word is in flight.
module audio_ring_fifo_volume_saturate_core
    import arfvs_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input words
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // [15:0] left_sample
    input  wire logic [0:0]        s_tuser,   // [0] command (0 push, 1 pop)
    // result words
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,   // [15:0] out_sample
    output logic [1:0]             m_tuser,   // [0] dropped, [1] was_empty
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // config registers
    logic [VOL_W-1:0] volume_reg;
    logic             mute_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg <= VOLUME_RESET;
            mute_reg   <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[2]))
                REG_VOLUME: volume_reg <= pwdata[VOL_W-1:0];
                REG_MUTE:   mute_reg   <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[2]))
            REG_VOLUME: prdata = 32'(volume_reg);
            REG_MUTE:   prdata = 32'(mute_reg);
            default:    prdata = '0;
        endcase
    end

    // pipeline control: stage 1 = ring read, stage 2 = output register
    logic s1_valid_reg;
    logic adv2;
    logic accept;

    assign adv2     = !m_tvalid || m_tready;
    assign s_tready = !s1_valid_reg || adv2;
    assign accept   = s_tvalid && s_tready;

    // ring pointers and status, decided at accept
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic             ring_full;
    logic             ring_empty;
    logic             is_pop;
    logic             do_write;
    logic             do_read;
    word_stat_t       stat_in;
    word_stat_t       s1_stat_reg;

    always_comb begin
        is_pop     = (cmd_t'(s_tuser[0]) == CMD_POP);
        ring_full  = (PTR_W'(wp_reg + 1'b1) == rp_reg);
        ring_empty = (rp_reg == wp_reg);
        do_write   = accept && !is_pop && !ring_full;
        do_read    = accept && is_pop && !ring_empty;
        wp_next    = do_write ? PTR_W'(wp_reg + 1'b1) : wp_reg;
        rp_next    = do_read  ? PTR_W'(rp_reg + 1'b1) : rp_reg;
        stat_in.cmd       = cmd_t'(s_tuser[0]);
        stat_in.dropped   = !is_pop && ring_full;
        stat_in.was_empty = is_pop && ring_empty;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_stat_reg <= stat_in;
        end
    end

    // read data holds while stalled since re only fires on accept
    logic [SAMPLE_W-1:0] ring_rdata;

    arfvs_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (wp_reg),
        .wdata (s_tdata),
        .re    (do_read),
        .raddr (rp_reg),
        .rdata (ring_rdata)
    );

    // stage 2: scale, clamp, register
    logic signed [SAMPLE_W-1:0] gain_out;

    arfvs_gain u_gain (
        .sample     ($signed(ring_rdata)),
        .volume     (volume_reg),
        .mute       (mute_reg),
        .stat       (s1_stat_reg),
        .out_sample (gain_out)
    );

    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_data_reg;
    logic [1:0]          m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv2) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && s1_valid_reg) begin
            m_data_reg <= gain_out;
            m_user_reg <= {s1_stat_reg.was_empty, s1_stat_reg.dropped};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    // a push that fits advances the write pointer by one
    a_wp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        do_write |=> wp_reg == PTR_W'($past(wp_reg) + 1'b1))
        else $error("write pointer did not advance on push");

    // a pop never consumes from an empty ring
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        do_read |-> rp_reg != wp_reg)
        else $error("pop read from empty ring");

    // a word is either dropped, empty, or neither, never both
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("dropped and was_empty both set");

    // flagged words carry silence
    a_flag_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[0] || m_tuser[1])) |-> m_tdata == '0)
        else $error("flagged word with nonzero sample");

    // stage 1 holds its word while the output side is blocked
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !adv2) |=> s1_valid_reg && $stable(s1_stat_reg))
        else $error("stage 1 word lost under stall");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_audio_ring_fifo_volume_saturate_core.sv
// Self-checking testbench for audio_ring_fifo_volume_saturate_core.
// Depends on arfvs_pkg and the core RTL; keeps its own ring/gain predictor.
`timescale 1ns / 1ps

module tb_audio_ring_fifo_volume_saturate_core;
    import arfvs_pkg::*;

    localparam int QUIET_LIMIT = 5000;  // cycles without any handshake
    localparam int TAIL_CYCLES = 8;
    localparam int ERR_PRINTS  = 40;
    localparam int RANDOM_WORDS_PER_HALF = 16;
    localparam int HOLD_WORDS  = 64;
    localparam int OVERFLOW_PUSHES = 4;
    localparam int AFTER_FULL_POPS = 8;

    typedef struct {
        logic [15:0] sample;
        logic        dropped;
        logic        was_empty;
    } fifo_result_t;

    // DUT ports
    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;    // [15:0] left_sample
    logic [0:0]        s_tuser;    // [0] command
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;    // [15:0] out_sample
    logic [1:0]        m_tuser;    // [0] dropped, [1] was_empty
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Predictor state: ring contents, pointers, registers
    logic [15:0]      ring_copy [RING_DEPTH];
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] rd_ptr;
    logic [VOL_W-1:0] vol_gain;
    logic             mute_on;

    fifo_result_t pending_outputs[$];

    int err_count;
    int words_in;
    int words_out;
    int drop_count;
    int empty_count;

    // Idling knobs, percent of cycles, and a forced receiver hold-off count
    int send_idle_pct;
    int recv_stall_pct;
    int rx_hold_cycles;

    audio_ring_fifo_volume_saturate_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: one result per word, mirrors ring pointers and gain path
    // ------------------------------------------------------------------
    function automatic fifo_result_t ring_gain_predict(cmd_t cmd, logic [15:0] smp);
        fifo_result_t res;
        logic signed [15:0] stored;
        int scaled;
        res.sample    = '0;
        res.dropped   = 1'b0;
        res.was_empty = 1'b0;
        stored        = '0;
        if (cmd == CMD_PUSH) begin
            // one slot stays free: full when next write slot hits the read slot
            if (PTR_W'(wr_ptr + 1'b1) == rd_ptr) begin
                res.dropped = 1'b1;
            end else begin
                ring_copy[wr_ptr] = smp;
                wr_ptr = wr_ptr + 1'b1;
            end
        end else begin
            if (rd_ptr != wr_ptr) begin
                stored = ring_copy[rd_ptr];
                rd_ptr = rd_ptr + 1'b1;
            end else begin
                res.was_empty = 1'b1;
            end
            // arithmetic shift on a signed int rounds toward minus infinity
            scaled = mute_on ? 0 : (int'(stored) * int'(vol_gain)) >>> SHIFT;
            if (scaled > int'(SAMPLE_MAX))
                scaled = int'(SAMPLE_MAX);
            else if (scaled < int'(SAMPLE_MIN))
                scaled = int'(SAMPLE_MIN);
            res.sample = scaled[15:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        err_count++;
        if (err_count <= ERR_PRINTS)
            $display("mismatch %s at result word %0d: got %h, expected %h",
                     field, words_out, got, want);
    endtask

    // ------------------------------------------------------------------
    // Monitor: predict on input handshake, compare on output handshake
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        fifo_result_t want;
        if (aresetn && s_tvalid && s_tready) begin
            pending_outputs.push_back(ring_gain_predict(cmd_t'(s_tuser[0]), s_tdata));
            words_in++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch("unexpected word", {14'd0, m_tuser, m_tdata}, '0);
            end else begin
                want = pending_outputs.pop_front();
                if (m_tdata !== want.sample)
                    report_mismatch("out_sample", m_tdata, want.sample);
                if (m_tuser[0] !== want.dropped)
                    report_mismatch("dropped", m_tuser[0], want.dropped);
                if (m_tuser[1] !== want.was_empty)
                    report_mismatch("was_empty", m_tuser[1], want.was_empty);
                drop_count  += want.dropped;
                empty_count += want.was_empty;
            end
            words_out++;
        end
    end

    // Receiver: random stalls, or a forced hold-off counted down here
    always @(negedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run if no handshake of any kind happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_outputs.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Leaves tvalid high after acceptance; the next call replaces or lowers it, or wait_idle lowers it.
    task automatic send_word(cmd_t cmd, logic [15:0] smp);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering words, let every expected result arrive, then idle out
    // the pipeline. Returns just after a rising edge.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_outputs.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // APB write then read-back of the same register; only called with the
    // core drained.
    task automatic write_register(reg_idx_t idx, logic [31:0] value);
        logic [31:0] readback_want;
        wait_idle();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_VOLUME)
            vol_gain = value[VOL_W-1:0];
        else
            mute_on = value[0];
        readback_want = (idx == REG_VOLUME) ? 32'(vol_gain) : 32'(mute_on);
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== readback_want)
            report_mismatch("prdata", prdata, readback_want);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Empty pop, full-scale and alternating-bit samples through unity gain
    task automatic test_empty_and_extremes();
        set_idling(17, 17);
        send_word(CMD_POP, 16'hFFFF);
        send_word(CMD_PUSH, 16'h7FFF);
        send_word(CMD_PUSH, 16'h8000);
        send_word(CMD_PUSH, 16'h0001);
        send_word(CMD_PUSH, 16'hFFFF);
        send_word(CMD_PUSH, 16'h5555);
        send_word(CMD_PUSH, 16'hAAAA);
        repeat (6) send_word(CMD_POP, 16'h0000);
        send_word(CMD_POP, 16'h5555);
    endtask

    // Gain above unity saturates both ways; gain 1 floors small negatives
    task automatic test_gain_and_saturation();
        write_register(REG_VOLUME, 32'd511);
        send_word(CMD_PUSH, 16'h7FFF);
        send_word(CMD_PUSH, 16'h8000);
        send_word(CMD_PUSH, 16'hFF00);
        repeat (3) send_word(CMD_POP, 16'h0000);
        write_register(REG_VOLUME, 32'd1);
        send_word(CMD_PUSH, 16'hFFFF);
        send_word(CMD_POP, 16'h0000);
        write_register(REG_VOLUME, 32'(VOLUME_RESET));
    endtask

    // Muted pop still consumes its sample, the following pop finds it empty
    task automatic test_mute();
        write_register(REG_MUTE, 32'd1);
        send_word(CMD_PUSH, 16'h1234);
        send_word(CMD_POP, 16'h0000);
        send_word(CMD_POP, 16'h0000);
        write_register(REG_MUTE, 32'd0);
    endtask

    // Fill to the brim, overflow a few pushes, then pop a few from the full ring
    task automatic test_ring_full();
        int level;
        wait_idle();
        set_idling(0, 81);
        level = int'(PTR_W'(wr_ptr - rd_ptr));
        repeat (RING_DEPTH - 1 - level + OVERFLOW_PUSHES)
            send_word(CMD_PUSH, random_sample());
        repeat (AFTER_FULL_POPS) send_word(CMD_POP, 16'($urandom));
    endtask

    // Receiver holds off while the sender keeps offering; input must stall
    task automatic test_backpressure_fill();
        wait_idle();
        set_idling(0, 0);
        rx_hold_cycles = 300;
        repeat (HOLD_WORDS)
            send_word($urandom_range(0, 1) ? CMD_POP : CMD_PUSH, random_sample());
    endtask

    // Bursts lean toward push or pop so the ring level wanders
    task automatic run_random_traffic(int n_words);
        int push_pct;
        push_pct = 50;
        for (int i = 0; i < n_words; i++) begin
            if (i % 32 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 75;
                endcase
            end
            send_word(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP,
                      random_sample());
        end
    endtask

    // Four idling modes, two register settings in each
    task automatic test_random_phases();
        int setting;
        logic [31:0] vol;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       set_idling(0, 0);
                1:       set_idling(81, 0);
                2:       set_idling(0, 81);
                default: set_idling(17, 17);
            endcase
            for (int half = 0; half < 2; half++) begin
                setting = phase * 2 + half;
                case (setting)
                    0:       vol = 32'd256;
                    1:       vol = 32'd511;
                    2:       vol = 32'd0;
                    3:       vol = 32'd1;
                    default: vol = $urandom_range(0, 511);
                endcase
                write_register(REG_VOLUME, vol);
                write_register(REG_MUTE, ($urandom_range(0, 3) == 0) ? 32'd1 : 32'd0);
                run_random_traffic(RANDOM_WORDS_PER_HALF);
            end
        end
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        wr_ptr         = '0;
        rd_ptr         = '0;
        vol_gain       = VOLUME_RESET;
        mute_on        = 1'b0;
        err_count      = 0;
        words_in       = 0;
        words_out      = 0;
        drop_count     = 0;
        empty_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rx_hold_cycles = 0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_and_extremes();
        test_gain_and_saturation();
        test_mute();
        test_backpressure_fill();
        test_random_phases();
        test_ring_full();
        wait_idle();

        $display("covered %0d words in, %0d results out: %0d full-ring drops, %0d empty pops",
                 words_in, words_out, drop_count, empty_count);
        $display("gain extremes 0/1/256/511, mute on and off, long output hold-off, 4 idling modes");
        if (err_count == 0 && pending_outputs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", err_count, pending_outputs.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
